// ===== src/srps_pkg.sv =====
`timescale 1ns / 1ps

package srps_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);

	localparam int PERIOD_W  = 16;
	localparam int COMPARE_W = 15;
	localparam int ACCEL_W   = 9;
	localparam int CRUISE_W  = 16;
	localparam int TIDX_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [ACCEL_W-1:0]  ACCEL_LENGTH_RST = 9'd256;
	localparam logic [CRUISE_W-1:0] CRUISE_STEPS_RST = 16'd900;

	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CRUISE_STEPS = 1'd1;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] PH_CODE_ACCEL  = 2'd0;
	localparam logic [1:0] PH_CODE_CRUISE = 2'd1;
	localparam logic [1:0] PH_CODE_DECEL  = 2'd2;
	localparam logic [1:0] PH_CODE_STOP   = 2'd3;

	typedef enum logic [3:0] {
		PH_ACCEL  = 4'b0001,
		PH_CRUISE = 4'b0010,
		PH_DECEL  = 4'b0100,
		PH_STOP   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       update;
		logic [1:0] phase;
		logic       channel_off;
	} step_info_t;

	function automatic logic [1:0] phase_code(phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_ACCEL:  code = PH_CODE_ACCEL;
			PH_CRUISE: code = PH_CODE_CRUISE;
			PH_DECEL:  code = PH_CODE_DECEL;
			PH_STOP:   code = PH_CODE_STOP;
			default:   code = PH_CODE_ACCEL;
		endcase
		return code;
	endfunction

endpackage

// ===== src/srps_ram.sv =====
`timescale 1ns / 1ps

module srps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/srps_ctrl.sv =====
`timescale 1ns / 1ps

module srps_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_accept,
	input  logic                            item_op,
	input  logic                            cfg_we,
	input  logic [srps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srps_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            rd_en,
	output logic [srps_pkg::TABLE_AW-1:0]   rd_addr,
	output srps_pkg::step_info_t            info
);

	import srps_pkg::*;

	logic [ACCEL_W-1:0]  accel_length_q;
	logic [CRUISE_W-1:0] cruise_steps_q;
	logic                half_step_q;
	logic [IDX_W-1:0]    ramp_index_q;
	phase_t              phase_q;
	logic [CRUISE_W-1:0] cruise_left_q;

	logic                half_step_d;
	logic [IDX_W-1:0]    ramp_index_d;
	phase_t              phase_d;
	logic [CRUISE_W-1:0] cruise_left_d;

	logic [IDX_W-1:0]    ramp_len;
	logic [IDX_W-1:0]    idx_inc;
	logic [IDX_W-1:0]    idx_dec;
	logic [CRUISE_W-1:0] left_dec;

	function automatic logic [TABLE_AW-1:0] clamp_addr(logic [IDX_W-1:0] idx);
		logic [TABLE_AW-1:0] a;
		if (32'(idx) >= TABLE_DEPTH) begin
			a = TABLE_AW'(TABLE_DEPTH - 1);
		end else begin
			a = idx[TABLE_AW-1:0];
		end
		return a;
	endfunction

	always_comb begin
		if (accel_length_q == '0) begin
			ramp_len = IDX_W'(1);
		end else if (32'(accel_length_q) > TABLE_DEPTH) begin
			ramp_len = IDX_W'(TABLE_DEPTH);
		end else begin
			ramp_len = IDX_W'(accel_length_q);
		end
		idx_inc  = (32'(ramp_index_q) < TABLE_DEPTH) ? ramp_index_q + IDX_W'(1) : ramp_index_q;
		idx_dec  = (ramp_index_q != '0) ? ramp_index_q - IDX_W'(1) : '0;
		left_dec = (cruise_left_q != '0) ? cruise_left_q - CRUISE_W'(1) : '0;
	end

	always_comb begin
		half_step_d      = half_step_q;
		ramp_index_d     = ramp_index_q;
		phase_d          = phase_q;
		cruise_left_d    = cruise_left_q;
		rd_en            = 1'b0;
		rd_addr          = clamp_addr(ramp_index_q);
		info.update      = 1'b0;
		info.phase       = phase_code(phase_q);
		info.channel_off = 1'b0;
		if (item_accept && item_op == OP_TICK) begin
			half_step_d = ~half_step_q;
			if (half_step_q) begin
				case (phase_q)
					PH_ACCEL: begin
						rd_en        = 1'b1;
						info.update  = 1'b1;
						ramp_index_d = idx_inc;
						if (idx_inc >= ramp_len) begin
							phase_d = PH_CRUISE;
						end
					end
					PH_CRUISE: begin
						cruise_left_d = left_dec;
						if (left_dec == '0) begin
							phase_d = PH_DECEL;
						end
					end
					PH_DECEL: begin
						rd_en        = 1'b1;
						rd_addr      = clamp_addr(idx_dec);
						info.update  = 1'b1;
						ramp_index_d = idx_dec;
						if (idx_dec == '0) begin
							phase_d = PH_STOP;
						end
					end
					default: begin
						info.channel_off = 1'b1;
						ramp_index_d     = '0;
						cruise_left_d    = cruise_steps_q;
						phase_d          = PH_ACCEL;
					end
				endcase
			end
		end else if (cfg_we && cfg_index == CFG_CRUISE_STEPS && phase_q == PH_ACCEL) begin
			cruise_left_d = cfg_data[CRUISE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_length_q <= ACCEL_LENGTH_RST;
			cruise_steps_q <= CRUISE_STEPS_RST;
			half_step_q    <= 1'b0;
			ramp_index_q   <= '0;
			phase_q        <= PH_ACCEL;
			cruise_left_q  <= CRUISE_STEPS_RST;
		end else begin
			if (cfg_we && cfg_index == CFG_ACCEL_LENGTH) begin
				accel_length_q <= cfg_data[ACCEL_W-1:0];
			end
			if (cfg_we && cfg_index == CFG_CRUISE_STEPS) begin
				cruise_steps_q <= cfg_data[CRUISE_W-1:0];
			end
			half_step_q   <= half_step_d;
			ramp_index_q  <= ramp_index_d;
			phase_q       <= phase_d;
			cruise_left_q <= cruise_left_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		32'(ramp_index_q) <= TABLE_DEPTH)
		else $error("ramp index ran past the table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_STOP) |-> (ramp_index_q == '0))
		else $error("stop phase entered with a nonzero ramp index");

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(phase_q))
		else $error("phase register is not one-hot");

endmodule

// ===== src/stepper_ramp_profile_sequencer_top.sv =====
`timescale 1ns / 1ps

// Results are registered in stage one (info_s1, table read data), then in the output register.
// Throughput: one input transaction per cycle, sustained while the master side keeps up.
// The period table read goes through the table memory's registered read port.
// Reset clears the phase state, ramp index, half-step flag and config registers to their defaults.
// The period table is not cleared by reset and holds no data until write transactions load it.

module stepper_ramp_profile_sequencer_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [23:0]                     s_tdata,  // table_index, table_value
	input  logic                            s_tuser,  // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata,  // reload, compare, phase, channel_off, zero pad
	output logic                            m_tuser,  // update
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [srps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srps_pkg::CFG_DATA_W-1:0] cfg_data
);

	import srps_pkg::*;

	logic                  accept;
	logic                  out_load;
	logic                  rd_en;
	logic [TABLE_AW-1:0]   rd_addr;
	logic [PERIOD_W-1:0]   rd_data;
	logic                  wr_en;
	step_info_t            info;

	logic                  valid_s1;
	step_info_t            info_s1;

	logic                  m_tvalid_q;
	logic                  update_q;
	logic [PERIOD_W-1:0]   reload_q;
	logic [COMPARE_W-1:0]  compare_q;
	logic [1:0]            phase_q;
	logic                  channel_off_q;
	logic [PERIOD_W-1:0]   reload_s1;

	assign cfg_ready = 1'b1;
	assign out_load  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready  = !valid_s1 || out_load;
	assign accept    = s_tvalid && s_tready;
	assign wr_en     = accept && s_tuser == OP_WRITE && 32'(s_tdata[TIDX_W-1:0]) < TABLE_DEPTH;
	assign reload_s1 = info_s1.update ? rd_data : '0;

	srps_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_accept (accept),
		.item_op     (s_tuser),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.info        (info)
	);

	srps_ram #(
		.WIDTH (PERIOD_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (TABLE_AW'(s_tdata[TIDX_W-1:0])),
		.wdata (s_tdata[TIDX_W +: PERIOD_W]),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
		if (out_load) begin
			update_q      <= info_s1.update;
			reload_q      <= reload_s1;
			compare_q     <= reload_s1[PERIOD_W-1:1];
			phase_q       <= info_s1.phase;
			channel_off_q <= info_s1.channel_off;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = update_q;
	assign m_tdata  = {6'd0, channel_off_q, phase_q, compare_q, reload_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[32:31] == PH_CODE_ACCEL ||
			m_tdata[32:31] == PH_CODE_DECEL))
		else $error("period update issued outside a ramp phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[33]) |-> (m_tdata[32:31] == PH_CODE_STOP && !m_tuser))
		else $error("channel turned off outside the stop phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[30:0] == '0))
		else $error("nonzero period on a result without an update");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_load) |=> (valid_s1 && $stable(info_s1)))
		else $error("stage one item lost while the output was stalled");

endmodule
